FILE: rtl/wsd_pkg.sv
`default_nettype none
package wsd_pkg;

    // Field widths of the byte stream and of one result
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned RSV_W    = 3;
    localparam int unsigned OPCODE_W = 4;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_EMPTY   = 1'b1;

    // One result transaction
    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   out_byte;
        logic                final_fragment;
        logic [RSV_W-1:0]    reserved_bits;
        logic [OPCODE_W-1:0] frame_opcode;
        logic                last_of_frame;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/wsd_byte_if.sv
`default_nettype none
interface wsd_byte_if
    import wsd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/wsd_result_if.sv
`default_nettype none
interface wsd_result_if
    import wsd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [BYTE_W-1:0]   out_byte;
    logic                final_fragment;
    logic [RSV_W-1:0]    reserved_bits;
    logic [OPCODE_W-1:0] frame_opcode;
    logic                last_of_frame;

    modport source (
        output valid, output kind, output out_byte, output final_fragment,
        output reserved_bits, output frame_opcode, output last_of_frame,
        input ready
    );
    modport sink (
        input valid, input kind, input out_byte, input final_fragment,
        input reserved_bits, input frame_opcode, input last_of_frame,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/wsd_out_skid.sv
`default_nettype none
module wsd_out_skid
    import wsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_data,
    input  wire logic    i_ready
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    // Accept while the skid slot is free
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    // Control: refill main from skid first, park a transaction when main stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_main_valid) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Data: follow the same choice as the control path
    always_ff @(posedge i_clk) begin
        if (i_ready || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_valid) begin
                r_main <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

    a_skid_only_when_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid slot holds data while main slot is empty");

    a_stalled_main_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && !i_ready) |=> (r_main_valid && $stable(r_main)))
        else $error("stalled result changed");

    a_no_loss_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> r_skid_valid)
        else $error("parked transaction dropped");

endmodule
`default_nettype wire

FILE: rtl/websocket_frame_deframer.sv
// Channel   Dir   Modport  Payload
// i_in      in    sink     data_byte[7:0]
// o_out     out   source   kind, out_byte[7:0], final_fragment, reserved_bits[2:0],
//                          frame_opcode[3:0], last_of_frame
//
// One byte is taken every cycle unless a stall on o_out backs up; each byte passes an
// input register and then the header/unmask logic into a two-entry result stage, where
// its result is registered. The per-byte length down-count (64-bit decrement and
// compare) sets the path between the input register and the result stage.
// Reset (synchronous, active low) returns the parser to the first header byte.
// A stall on o_out backs up into the result stage, then the input register.
`default_nettype none
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wsd_byte_if.sink     i_in,
    wsd_result_if.source o_out
);

    localparam logic [2:0] PH_BYTE0   = 3'd0;
    localparam logic [2:0] PH_BYTE1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Parser state
    logic [2:0]          r_phase,    n_phase;
    logic                r_fin,      n_fin;
    logic [RSV_W-1:0]    r_rsv,      n_rsv;
    logic [OPCODE_W-1:0] r_opcode,   n_opcode;
    logic                r_mask,     n_mask;
    logic [3:0]          r_ext_left, n_ext_left;
    logic [63:0]         r_len,      n_len;
    logic [31:0]         r_key,      n_key;
    logic [2:0]          r_key_left, n_key_left;
    logic [1:0]          r_idx,      n_idx;

    logic    w_adv;
    logic    w_res_valid;
    t_result w_res;
    logic    w_skid_ready;
    t_result w_out;

    // Advance the input register when the result stage has room
    assign w_adv      = r_in_valid && w_skid_ready;
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    // Parse one byte
    always_comb begin
        logic [63:0] len_new;
        logic [3:0]  ext_dec;
        logic [2:0]  key_dec;
        logic        enter_payload;
        logic        go_key;
        logic [7:0]  key_byte;

        n_phase    = r_phase;
        n_fin      = r_fin;
        n_rsv      = r_rsv;
        n_opcode   = r_opcode;
        n_mask     = r_mask;
        n_ext_left = r_ext_left;
        n_len      = r_len;
        n_key      = r_key;
        n_key_left = r_key_left;
        n_idx      = r_idx;

        len_new       = r_len;
        ext_dec       = r_ext_left - 4'd1;
        key_dec       = r_key_left - 3'd1;
        enter_payload = 1'b0;
        go_key        = 1'b0;
        key_byte      = 8'd0;

        w_res_valid          = 1'b0;
        w_res.kind           = KIND_PAYLOAD;
        w_res.out_byte       = r_in_byte;
        w_res.final_fragment = r_fin;
        w_res.reserved_bits  = r_rsv;
        w_res.frame_opcode   = r_opcode;
        w_res.last_of_frame  = 1'b0;

        unique case (r_phase)
            PH_BYTE1: begin
                n_mask = r_in_byte[7];
                if (r_in_byte[6:0] < LEN_EXT16) begin
                    len_new    = {57'd0, r_in_byte[6:0]};
                    n_len      = len_new;
                    n_ext_left = 4'd0;
                    go_key     = r_in_byte[7];
                    enter_payload = !r_in_byte[7];
                end else begin
                    n_len      = 64'd0;
                    n_ext_left = (r_in_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    n_phase    = PH_EXTLEN;
                end
            end
            PH_EXTLEN: begin
                len_new    = {r_len[55:0], r_in_byte};
                n_len      = len_new;
                n_ext_left = ext_dec;
                if (ext_dec == 4'd0) begin
                    go_key        = r_mask;
                    enter_payload = !r_mask;
                end
            end
            PH_KEY: begin
                n_key      = {r_key[23:0], r_in_byte};
                n_key_left = key_dec;
                if (key_dec == 3'd0) begin
                    enter_payload = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                case (r_idx)
                    2'd0:    key_byte = r_key[31:24];
                    2'd1:    key_byte = r_key[23:16];
                    2'd2:    key_byte = r_key[15:8];
                    default: key_byte = r_key[7:0];
                endcase
                w_res_valid         = 1'b1;
                w_res.out_byte      = r_mask ? (r_in_byte ^ key_byte) : r_in_byte;
                w_res.last_of_frame = (r_len == 64'd1);
                n_idx               = r_idx + 2'd1;
                n_len               = r_len - 64'd1;
                if (r_len == 64'd1) begin
                    n_phase = PH_BYTE0;
                end
            end
            default: begin
                n_fin    = r_in_byte[7];
                n_rsv    = r_in_byte[6:4];
                n_opcode = r_in_byte[3:0];
                n_phase  = PH_BYTE1;
            end
        endcase

        // Collect the masking key after the length
        if (go_key) begin
            n_key_left = KEY_BYTES;
            n_phase    = PH_KEY;
        end

        // Start the payload, or mark an empty frame
        if (enter_payload) begin
            n_idx = 2'd0;
            if (len_new == 64'd0) begin
                n_phase             = PH_BYTE0;
                w_res_valid         = 1'b1;
                w_res.kind          = KIND_EMPTY;
                w_res.out_byte      = 8'd0;
                w_res.last_of_frame = 1'b1;
            end else begin
                n_phase = PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BYTE0;
        end else if (w_adv) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fin      <= n_fin;
            r_rsv      <= n_rsv;
            r_opcode   <= n_opcode;
            r_mask     <= n_mask;
            r_ext_left <= n_ext_left;
            r_len      <= n_len;
            r_key      <= n_key;
            r_key_left <= n_key_left;
            r_idx      <= n_idx;
        end
    end

    // Result stage
    wsd_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_adv && w_res_valid),
        .i_data  (w_res),
        .o_ready (w_skid_ready),
        .o_valid (o_out.valid),
        .o_data  (w_out),
        .i_ready (o_out.ready)
    );

    assign o_out.kind           = w_out.kind;
    assign o_out.out_byte       = w_out.out_byte;
    assign o_out.final_fragment = w_out.final_fragment;
    assign o_out.reserved_bits  = w_out.reserved_bits;
    assign o_out.frame_opcode   = w_out.frame_opcode;
    assign o_out.last_of_frame  = w_out.last_of_frame;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_PAYLOAD)
        else $error("parser phase out of range");

    a_payload_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_len != 64'd0))
        else $error("payload phase with no bytes left");

    a_ext_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXTLEN) |-> (r_ext_left != 4'd0 && r_ext_left <= EXT64_BYTES))
        else $error("extended length count out of range");

    a_key_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_KEY) |-> (r_key_left != 3'd0 && r_key_left <= KEY_BYTES))
        else $error("masking key count out of range");

    a_frame_end_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_res_valid && w_res.last_of_frame) |=> (r_phase == PH_BYTE0))
        else $error("last result did not return parser to first header byte");

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none
module tb_top;
    import wsd_pkg::*;

    // Phases of the parser as tracked by the scoreboard
    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD
    } t_phase;

    // How the length of a generated frame is encoded on the wire
    typedef enum int {
        LEN_FORM_SHORT,
        LEN_FORM_16,
        LEN_FORM_64
    } t_len_form;

    // Receiver back-pressure styles
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_PERIODIC,
        RX_STARVED
    } t_rx_mode;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam int unsigned STREAM_TARGET = 1100;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS = 40;

    logic i_clk;
    logic i_rst_n;

    wsd_byte_if   in_if ();
    wsd_result_if out_if ();

    websocket_frame_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Raw bytes still to be sent, and results the scoreboard is waiting for
    logic [7:0] stream_bytes[$];
    t_result    pending_results[$];
    int unsigned error_count = 0;

    // Scoreboard copy of the parser state
    t_phase      sb_phase    = PH_HDR0;
    logic        sb_fin      = 1'b0;
    logic [2:0]  sb_rsv      = '0;
    logic [3:0]  sb_opcode   = '0;
    logic        sb_masked   = 1'b0;
    logic [3:0]  sb_ext_left = '0;
    logic [63:0] sb_length   = '0;
    logic [31:0] sb_key      = '0;
    logic [2:0]  sb_key_left = '0;
    logic [63:0] sb_index    = '0;

    // Clock and initial levels of every input
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        out_if.ready = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result make_result(input logic kind, input logic [7:0] data,
                                            input logic last);
        t_result r;
        r.kind = kind;
        r.out_byte = data;
        r.final_fragment = sb_fin;
        r.reserved_bits = sb_rsv;
        r.frame_opcode = sb_opcode;
        r.last_of_frame = last;
        return r;
    endfunction

    // Header done: enter payload, or flag an empty frame
    function automatic bit start_payload(output t_result r);
        sb_index = '0;
        r = '0;
        if (sb_length == 0) begin
            sb_phase = PH_HDR0;
            r = make_result(KIND_EMPTY, 8'h00, 1'b1);
            return 1'b1;
        end
        sb_phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    // Length done: collect the masking key first if the frame is masked
    function automatic bit finish_length(output t_result r);
        r = '0;
        if (sb_masked) begin
            sb_key = '0;
            sb_key_left = 3'd4;
            sb_phase = PH_KEY;
            return 1'b0;
        end
        return start_payload(r);
    endfunction

    // Advance the scoreboard by one received byte; return 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        logic [7:0] key_byte;
        logic       last;
        r = '0;
        case (sb_phase)
            PH_HDR1: begin
                sb_masked = b[7];
                if (b[6:0] < LEN_EXT16) begin
                    sb_length = 64'(b[6:0]);
                    sb_ext_left = '0;
                    return finish_length(r);
                end
                sb_length = '0;
                sb_ext_left = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                sb_phase = PH_EXTLEN;
                return 1'b0;
            end
            PH_EXTLEN: begin
                sb_length = {sb_length[55:0], b};
                sb_ext_left = sb_ext_left - 4'd1;
                if (sb_ext_left == 0) return finish_length(r);
                return 1'b0;
            end
            PH_KEY: begin
                sb_key = {sb_key[23:0], b};
                sb_key_left = sb_key_left - 3'd1;
                if (sb_key_left == 0) return start_payload(r);
                return 1'b0;
            end
            PH_PAYLOAD: begin
                // First key byte received unmasks payload byte 0
                key_byte = sb_masked ? sb_key[8 * (3 - sb_index[1:0]) +: 8] : 8'h00;
                sb_index = sb_index + 64'd1;
                last = (sb_index == sb_length);
                if (last) sb_phase = PH_HDR0;
                r = make_result(KIND_PAYLOAD, b ^ key_byte, last);
                return 1'b1;
            end
            default: begin
                sb_fin = b[7];
                sb_rsv = b[6:4];
                sb_opcode = b[3:0];
                sb_phase = PH_HDR1;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (error_count < MAX_REPORTS)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Append one frame; n_payload below the length leaves the frame open
    task automatic add_frame(input logic [7:0] head, input bit masked,
                             input logic [63:0] length, input t_len_form form,
                             input int unsigned n_payload);
        int unsigned sel;
        stream_bytes.push_back(head);
        case (form)
            LEN_FORM_16: begin
                stream_bytes.push_back({masked, LEN_EXT16});
                stream_bytes.push_back(length[15:8]);
                stream_bytes.push_back(length[7:0]);
            end
            LEN_FORM_64: begin
                stream_bytes.push_back({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--) stream_bytes.push_back(length[8 * i +: 8]);
            end
            default: stream_bytes.push_back({masked, length[6:0]});
        endcase
        if (masked)
            for (int i = 0; i < 4; i++) stream_bytes.push_back(8'($urandom));
        for (int unsigned i = 0; i < n_payload; i++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) stream_bytes.push_back(8'h00);
            else if (sel == 1) stream_bytes.push_back(8'hFF);
            else stream_bytes.push_back(8'($urandom));
        end
    endtask

    // Directed frames, random frames, then an open frame with a huge length
    initial begin
        logic [7:0]  head;
        logic [63:0] length;
        t_len_form   form;
        int unsigned pick;
        bit          masked;

        stream_bytes.push_back(8'h81);
        stream_bytes.push_back(8'h00);
        add_frame(8'h7A, 1'b1, 64'd0, LEN_FORM_SHORT, 0);
        stream_bytes.push_back(8'hF0);
        stream_bytes.push_back(8'h01);
        stream_bytes.push_back(8'hFF);
        add_frame(8'h8F, 1'b0, 64'd0, LEN_FORM_16, 0);
        stream_bytes.push_back(8'h02);
        stream_bytes.push_back({1'b1, LEN_EXT64});
        for (int i = 0; i < 7; i++) stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'h02);
        stream_bytes.push_back(8'hAA);
        stream_bytes.push_back(8'h55);
        stream_bytes.push_back(8'hF0);
        stream_bytes.push_back(8'h0F);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);

        while (stream_bytes.size() < STREAM_TARGET) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) head = 8'($urandom);
            else head = {1'($urandom), 3'b000, 4'($urandom_range(0, 2))};
            masked = 1'($urandom);
            pick = $urandom_range(0, 19);
            if (pick < 11) begin
                length = 64'($urandom_range(0, 15));
                form = LEN_FORM_SHORT;
            end else if (pick < 14) begin
                length = 64'($urandom_range(16, 125));
                form = LEN_FORM_SHORT;
            end else if (pick < 16) begin
                length = 64'($urandom_range(126, 300));
                form = LEN_FORM_16;
            end else if (pick < 18) begin
                // Non-minimal encoding of a short length
                length = 64'($urandom_range(0, 20));
                form = LEN_FORM_16;
            end else begin
                length = 64'($urandom_range(0, 40));
                form = LEN_FORM_64;
            end
            add_frame(head, masked, length, form, int'(length));
        end

        // Length with its top bit set is taken as given; the frame never ends
        add_frame(8'h82, 1'b1, {1'b1, 63'($urandom)}, LEN_FORM_64, 20);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every byte to be taken and every result to arrive
        do @(negedge i_clk);
        while (stream_bytes.size() != 0 || in_if.valid || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (gap_left != 0 || stream_bytes.size() == 0) begin
                in_if.valid <= 1'b0;
                if (gap_left != 0) gap_left--;
            end else begin
                in_if.valid <= 1'b1;
                in_if.data_byte <= stream_bytes.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Receiver: pick a new back-pressure style at random whenever the low byte of rx_cycle is FF
    t_rx_mode    rx_mode = RX_ALWAYS;
    logic [31:0] rx_cycle = '0;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 32'd1;
        if (rx_cycle[7:0] == 8'hFF) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS:   out_if.ready <= 1'b1;
            RX_MOSTLY:   out_if.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: out_if.ready <= rx_cycle[2];
            default:     out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Monitor: predict on each accepted byte, then check each accepted result
    always @(posedge i_clk) begin
        t_result predicted;
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                if (deframe_byte(in_if.data_byte, predicted))
                    pending_results.push_back(predicted);
            if (out_if.valid && out_if.ready) begin
                got.kind = out_if.kind;
                got.out_byte = out_if.out_byte;
                got.final_fragment = out_if.final_fragment;
                got.reserved_bits = out_if.reserved_bits;
                got.frame_opcode = out_if.frame_opcode;
                got.last_of_frame = out_if.last_of_frame;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", got.out_byte, 8'h00);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("kind", 8'(got.kind), 8'(want.kind));
                    if (got.out_byte !== want.out_byte)
                        report_mismatch("out_byte", got.out_byte, want.out_byte);
                    if (got.final_fragment !== want.final_fragment)
                        report_mismatch("final_fragment", 8'(got.final_fragment),
                                        8'(want.final_fragment));
                    if (got.reserved_bits !== want.reserved_bits)
                        report_mismatch("reserved_bits", 8'(got.reserved_bits),
                                        8'(want.reserved_bits));
                    if (got.frame_opcode !== want.frame_opcode)
                        report_mismatch("frame_opcode", 8'(got.frame_opcode),
                                        8'(want.frame_opcode));
                    if (got.last_of_frame !== want.last_of_frame)
                        report_mismatch("last_of_frame", 8'(got.last_of_frame),
                                        8'(want.last_of_frame));
                end
            end
        end
    end

    // Hard stop if the stream hangs
    initial begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
rtl/wsd_pkg.sv
rtl/wsd_byte_if.sv
rtl/wsd_result_if.sv
rtl/wsd_out_skid.sv
rtl/websocket_frame_deframer.sv
dv/tb_top.sv
